/* sv/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad combination lock
// Key codes, event codes, lock modes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

    localparam int DIGITS_DEFAULT = 4;

    localparam logic [7:0] KEY_NONE   = 8'd255;
    localparam logic [7:0] KEY_IGNORE = 8'd78;   // 'N'
    localparam logic [7:0] KEY_CHANGE = 8'd67;   // 'C'
    localparam logic [7:0] KEY_OPEN   = 8'd79;   // 'O'
    localparam logic [7:0] DIGIT_BASE = 8'd48;   // '0'

    typedef enum logic [2:0] {
        EV_ECHO    = 3'd0,
        EV_MENU    = 3'd1,
        EV_WRONG   = 3'd2,
        EV_CONFIRM = 3'd3,
        EV_CHANGED = 3'd4,
        EV_NEW     = 3'd5,
        EV_OPENED  = 3'd6,
        EV_ERROR   = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        MODE_VERIFY  = 3'b001,
        MODE_NEW     = 3'b010,
        MODE_CONFIRM = 3'b100
    } mode_t;

    typedef struct packed {
        logic       has_result;
        event_t     event_res;
        logic [7:0] echo_char;
        logic [1:0] digit_position;
        logic       unlock;
    } result_t;

endpackage

`default_nettype wire

/* sv/keypad_combination_lock.sv */
// ----------------------------------------------------------------------------
// keypad_combination_lock: four-digit keypad lock with password change menu
// Input register, combinational key decode, result register.
// ----------------------------------------------------------------------------
// One keypad code per transfer; the block takes a new code every cycle unless
// a waiting result holds it back. Each code leaves as a result through the
// input and then the result register, or leaves none for "no key" (255) or 'N'.
// Digits are echoed as entered; the last digit of an entry reports menu,
// wrong, confirm prompt or changed depending on the lock mode. With the menu
// open, 'C' starts a password change, 'O' pulses unlock and any other key
// reports an error. The stored password resets to 0xFF in every digit. The
// input register can still take a code while a result waits on m_ready, so the
// two sides are decoupled by one item; rate is one transfer per cycle while no
// result is held back, set by the single decode step between the two registers.
`default_nettype none

module keypad_combination_lock #(
    parameter int DIGITS = kcl_pkg::DIGITS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output      logic       s_ready,
    input  wire logic [7:0] s_key_code,
    output      logic       m_valid,
    input  wire logic       m_ready,
    output      logic [2:0] m_event_res,
    output      logic [7:0] m_echo_char,
    output      logic [1:0] m_digit_position,
    output      logic       m_unlock
);

    logic             in_valid_reg;
    logic [7:0]       in_key_reg;
    logic             out_valid_reg;
    kcl_pkg::result_t out_reg;
    kcl_pkg::result_t result;
    logic             out_free;
    logic             advance;

    // Result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // Ignored keys retire without needing result space
    assign advance  = in_valid_reg && (!result.has_result || out_free);
    assign s_ready  = !in_valid_reg || advance;

    kcl_core #(
        .DIGITS (DIGITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .key_code (in_key_reg),
        .result   (result)
    );

    // Input register: hold the code until the decode step retires it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_key_reg <= s_key_code;
        end
    end

    // Result register: load on a producing step, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && result.has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.has_result) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_res      = out_reg.event_res;
    assign m_echo_char      = out_reg.echo_char;
    assign m_digit_position = out_reg.digit_position;
    assign m_unlock         = out_reg.unlock;

endmodule

`default_nettype wire

/* sv/kcl_core.sv */
// ----------------------------------------------------------------------------
// kcl_core: lock state and per-key decision logic
// Holds mode, entry count and the digit stores; decodes one key per step.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_core #(
    parameter int DIGITS = kcl_pkg::DIGITS_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       key_code,
    output kcl_pkg::result_t      result
);

    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    kcl_pkg::mode_t   mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       entered_reg [DIGITS];
    logic [7:0]       pending_reg [DIGITS];
    logic [7:0]       stored_reg  [DIGITS];
    logic [7:0]       entry_vec   [DIGITS];

    logic             digit_we, pending_we, stored_we;
    logic [7:0]       digit_val;
    logic [POS_W-1:0] idx;
    logic [CNT_W+1:0] cnt_ext;
    logic             match_stored, match_pending;
    logic             has_key;

    assign has_key   = (key_code != kcl_pkg::KEY_NONE) && (key_code != kcl_pkg::KEY_IGNORE);
    assign digit_val = key_code - kcl_pkg::DIGIT_BASE;
    assign idx       = cnt_reg[POS_W-1:0];
    assign cnt_ext   = {2'b00, cnt_reg};

    // Full entry with the current key merged at its position
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            entry_vec[i] = (idx == POS_W'(i)) ? digit_val : entered_reg[i];
        end
    end

    always_comb begin
        match_stored  = 1'b1;
        match_pending = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (entry_vec[i] != stored_reg[i]) begin
                match_stored = 1'b0;
            end
            if (entry_vec[i] != pending_reg[i]) begin
                match_pending = 1'b0;
            end
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        digit_we   = 1'b0;
        pending_we = 1'b0;
        stored_we  = 1'b0;
        result     = '{has_result: has_key, event_res: kcl_pkg::EV_ECHO,
                       echo_char: 8'd0, digit_position: 2'd0, unlock: 1'b0};
        if (has_key) begin
            if (cnt_reg >= CNT_FULL) begin
                // menu open: one command key, then back to entry
                cnt_next = '0;
                priority if (key_code == kcl_pkg::KEY_CHANGE) begin
                    mode_next        = kcl_pkg::MODE_NEW;
                    result.event_res = kcl_pkg::EV_NEW;
                end else if (key_code == kcl_pkg::KEY_OPEN) begin
                    result.event_res = kcl_pkg::EV_OPENED;
                    result.unlock    = 1'b1;
                end else begin
                    result.event_res = kcl_pkg::EV_ERROR;
                end
            end else begin
                digit_we              = 1'b1;
                result.echo_char      = key_code;
                result.digit_position = cnt_ext[1:0];
                if (cnt_reg != CNT_LAST) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    unique case (mode_reg)
                        kcl_pkg::MODE_VERIFY: begin
                            if (match_stored) begin
                                cnt_next         = CNT_FULL;
                                result.event_res = kcl_pkg::EV_MENU;
                            end else begin
                                cnt_next         = '0;
                                result.event_res = kcl_pkg::EV_WRONG;
                            end
                        end
                        kcl_pkg::MODE_NEW: begin
                            pending_we       = 1'b1;
                            mode_next        = kcl_pkg::MODE_CONFIRM;
                            cnt_next         = '0;
                            result.event_res = kcl_pkg::EV_CONFIRM;
                        end
                        kcl_pkg::MODE_CONFIRM: begin
                            cnt_next = '0;
                            if (match_pending) begin
                                stored_we        = 1'b1;
                                mode_next        = kcl_pkg::MODE_VERIFY;
                                result.event_res = kcl_pkg::EV_CHANGED;
                            end else begin
                                mode_next        = kcl_pkg::MODE_NEW;
                                result.event_res = kcl_pkg::EV_WRONG;
                            end
                        end
                        default: begin
                            result.event_res = kcl_pkg::EV_ECHO;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= kcl_pkg::MODE_VERIFY;
            cnt_reg  <= '0;
            for (int i = 0; i < DIGITS; i++) begin
                stored_reg[i] <= 8'hFF;
            end
        end else if (step) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            if (stored_we) begin
                for (int i = 0; i < DIGITS; i++) begin
                    stored_reg[i] <= pending_reg[i];
                end
            end
        end
    end

    // digit stores: no reset, always written before read
    always_ff @(posedge aclk) begin
        if (step && digit_we) begin
            entered_reg[idx] <= digit_val;
        end
        if (step && pending_we) begin
            for (int i = 0; i < DIGITS; i++) begin
                pending_reg[i] <= entry_vec[i];
            end
        end
    end

endmodule

`default_nettype wire
